@@ sv/scfa_pkg.sv @@
// Shared types, constants and the slot-size table of the size-class allocator.
`timescale 1ns / 1ps

package scfa_pkg;

   // Fixed geometry
   localparam int unsigned NUM_CLASSES        = 9;
   localparam int unsigned REGION_SIZE_DEF    = 1048576;
   localparam int unsigned OFFSET_SPACE       = 1048576;
   localparam int unsigned OFFSET_W           = 20;
   localparam int unsigned LINK_AW            = 15;
   localparam int unsigned GRANULE_SHIFT      = 5;
   localparam int unsigned CLASS_W            = 4;
   localparam int unsigned SLOT_W             = 13;
   localparam int unsigned BYTES_W            = 48;
   localparam int unsigned SIZE_W             = 32;
   localparam int unsigned LIVE_W             = 40;
   localparam int unsigned FACTOR_W           = 4;
   localparam int unsigned STATUS_W           = 3;
   localparam int unsigned CSR_AW             = 5;
   localparam int unsigned CSR_DW             = 64;

   // Reset values of budget state and registers
   localparam logic [BYTES_W-1:0]  THRESHOLD_RESET = 48'd16777216;
   localparam logic [LIVE_W-1:0]   TMIN_RESET      = 40'd16777216;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET    = 4'd2;

   // Request function codes
   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_ENDC  = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FROM_LIST = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BUMPED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_COLLECT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LARGE     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd6;

   // Configuration register indexes (byte address 8*index)
   localparam logic [1:0] CFG_STRESS = 2'd0;
   localparam logic [1:0] CFG_TMIN   = 2'd1;
   localparam logic [1:0] CFG_FACTOR = 2'd2;

   // Class lookup result
   typedef struct packed {
      logic               oversize;
      logic [CLASS_W-1:0] cls;
      logic [SLOT_W-1:0]  slot_bytes;
   } class_info_type;

   // Slot bytes of each class
   function automatic logic [SLOT_W-1:0] class_bytes(input logic [CLASS_W-1:0] idx);
      logic [SLOT_W-1:0] b;
      case (idx)
         4'd0:    b = 13'd32;
         4'd1:    b = 13'd64;
         4'd2:    b = 13'd128;
         4'd3:    b = 13'd256;
         4'd4:    b = 13'd512;
         4'd5:    b = 13'd1024;
         4'd6:    b = 13'd2048;
         4'd7:    b = 13'd3072;
         4'd8:    b = 13'd4096;
         default: b = 13'd0;
      endcase
      return b;
   endfunction

endpackage

@@ sv/scfa_class_dec.sv @@
// Size-to-class decoder: rounds a byte size up to a multiple of 8 and picks the smallest fitting class.
`timescale 1ns / 1ps

module scfa_class_dec (
   input  logic [scfa_pkg::SIZE_W-1:0] size_bytes,
   output scfa_pkg::class_info_type    info
);

   logic [scfa_pkg::SIZE_W:0] rounded;

   // Round up to an 8-byte multiple, one extra bit for the carry
   assign rounded = ({1'b0, size_bytes} + 33'd7) & ~33'd7;

   // Smallest class whose slot holds the rounded size
   always_comb begin
      info.oversize   = 1'b1;
      info.cls        = '0;
      info.slot_bytes = '0;
      for (int i = scfa_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
         if (rounded <= {20'd0, scfa_pkg::class_bytes(scfa_pkg::CLASS_W'(i))}) begin
            info.oversize   = 1'b0;
            info.cls        = scfa_pkg::CLASS_W'(i);
            info.slot_bytes = scfa_pkg::class_bytes(scfa_pkg::CLASS_W'(i));
         end
      end
   end

endmodule

@@ sv/size_class_freelist_allocator_top.sv @@
// Top level of the size-class free-list allocator with bump fallback.
//
// Request channel (req_*): func, size_bytes, slot_offset, live count, retry.
// A request is taken at a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): one response per request, in order: status,
// result_offset, size_class, slot_bytes, held while rsp_stall is high.
// Registers (stress_mode, threshold_minimum, threshold_factor) sit on an
// APB port at byte addresses 0, 8 and 16, 64-bit data, pready tied high.
//
// A request passes from acceptance to a registered response through
// accept, then execute; an alloc that pops a free list also passes through
// a pop state, since the next-link read from the link RAM is registered
// before the list head can be rewritten. One request is in flight at a
// time, so a new request is not taken until the last has left execute or pop.
// A response waiting in the output register does not block acceptance of
// the next request; that request waits in execute until the output frees.
// Synchronous reset empties all lists, zeroes the bump pointer and byte
// count and restores the register defaults; the link RAM is not cleared.
`timescale 1ns / 1ps

module size_class_freelist_allocator_top #(
   parameter int unsigned REGION_SIZE_BYTES = scfa_pkg::REGION_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_func,
   input  logic [scfa_pkg::SIZE_W-1:0]      req_size_bytes,
   input  logic [scfa_pkg::OFFSET_W-1:0]    req_slot_offset,
   input  logic [scfa_pkg::LIVE_W-1:0]      req_live_count,
   input  logic                             req_retry,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [scfa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [scfa_pkg::OFFSET_W-1:0]    rsp_result_offset,
   output logic [scfa_pkg::CLASS_W-1:0]     rsp_size_class,
   output logic [scfa_pkg::SLOT_W-1:0]      rsp_slot_bytes,
   // configuration port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [scfa_pkg::CSR_AW-1:0]      paddr,
   input  logic [scfa_pkg::CSR_DW-1:0]      pwdata,
   output logic [scfa_pkg::CSR_DW-1:0]      prdata,
   output logic                             pready
);

   localparam int unsigned RegionLimitInt =
      (REGION_SIZE_BYTES < scfa_pkg::OFFSET_SPACE) ? REGION_SIZE_BYTES
                                                   : scfa_pkg::OFFSET_SPACE;
   localparam logic [scfa_pkg::OFFSET_W+1:0] RegionLimit =
      (scfa_pkg::OFFSET_W+2)'(RegionLimitInt);
   localparam int unsigned LinkDepth = 1 << scfa_pkg::LINK_AW;
   localparam int unsigned LinkW     = scfa_pkg::OFFSET_W + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_POP} state_type;

   // control state
   state_type                              state_ff, state_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [scfa_pkg::NUM_CLASSES-1:0]       head_valid_ff, head_valid_in;
   logic [scfa_pkg::OFFSET_W:0]            bump_ff, bump_in;
   logic [scfa_pkg::BYTES_W-1:0]           bytes_ff, bytes_in;
   logic [scfa_pkg::BYTES_W-1:0]           thr_ff, thr_in;
   logic                                   stress_ff, stress_in;
   logic [scfa_pkg::LIVE_W-1:0]            tmin_ff, tmin_in;
   logic [scfa_pkg::FACTOR_W-1:0]          factor_ff, factor_in;

   // payload state
   logic [scfa_pkg::OFFSET_W-1:0]          head_off_ff [scfa_pkg::NUM_CLASSES];
   logic [scfa_pkg::OFFSET_W-1:0]          head_off_in [scfa_pkg::NUM_CLASSES];
   logic [1:0]                             func_ff, func_in;
   logic [scfa_pkg::SIZE_W-1:0]            size_ff, size_in;
   logic [scfa_pkg::OFFSET_W-1:0]          offset_ff, offset_in;
   logic [scfa_pkg::LIVE_W-1:0]            live_ff, live_in;
   logic                                   retry_ff, retry_in;
   logic [scfa_pkg::STATUS_W-1:0]          status_ff, status_in;
   logic [scfa_pkg::OFFSET_W-1:0]          roff_ff, roff_in;
   logic [scfa_pkg::CLASS_W-1:0]           rcls_ff, rcls_in;
   logic [scfa_pkg::SLOT_W-1:0]            rsb_ff, rsb_in;

   // link RAM
   logic [LinkW-1:0]                       link_mem [LinkDepth];
   logic [LinkW-1:0]                       link_rdata_ff;
   logic                                   mem_we, mem_re;
   logic [scfa_pkg::LINK_AW-1:0]           mem_waddr, mem_raddr;
   logic [LinkW-1:0]                       mem_wdata;

   // datapath
   scfa_pkg::class_info_type               cinfo;
   logic                                   out_free;
   logic [scfa_pkg::BYTES_W:0]             bytes_sum;
   logic [scfa_pkg::BYTES_W-1:0]           bytes_sat;
   logic                                   over_budget;
   logic [scfa_pkg::OFFSET_W+1:0]          bump_end;
   logic [scfa_pkg::OFFSET_W+1:0]          free_end;
   logic [scfa_pkg::LIVE_W+scfa_pkg::FACTOR_W-1:0] thr_prod;
   logic [scfa_pkg::LIVE_W+scfa_pkg::FACTOR_W-1:0] thr_next;
   logic                                   cfg_wr;

   scfa_class_dec u_class_dec (
      .size_bytes (size_ff),
      .info       (cinfo)
   );

   // budget arithmetic
   assign bytes_sum   = {1'b0, bytes_ff} + {17'd0, size_ff};
   assign bytes_sat   = bytes_sum[scfa_pkg::BYTES_W] ? '1 : bytes_sum[scfa_pkg::BYTES_W-1:0];
   assign over_budget = bytes_sum > {1'b0, thr_ff};
   assign thr_prod    = live_ff * factor_ff;
   assign thr_next    = (thr_prod < {4'd0, tmin_ff}) ? {4'd0, tmin_ff} : thr_prod;

   // region bound checks
   assign bump_end = {1'b0, bump_ff} + {9'd0, cinfo.slot_bytes};
   assign free_end = {2'b00, offset_ff} + {9'd0, cinfo.slot_bytes};

   // output register is free when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign cfg_wr    = psel && penable && pwrite;

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      head_valid_in = head_valid_ff;
      head_off_in   = head_off_ff;
      bump_in       = bump_ff;
      bytes_in      = bytes_ff;
      thr_in        = thr_ff;
      stress_in     = stress_ff;
      tmin_in       = tmin_ff;
      factor_in     = factor_ff;
      func_in       = func_ff;
      size_in       = size_ff;
      offset_in     = offset_ff;
      live_in       = live_ff;
      retry_in      = retry_ff;
      status_in     = status_ff;
      roff_in       = roff_ff;
      rcls_in       = rcls_ff;
      rsb_in        = rsb_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = offset_ff[scfa_pkg::OFFSET_W-1:scfa_pkg::GRANULE_SHIFT];
      mem_wdata     = {head_valid_ff[cinfo.cls], head_off_ff[cinfo.cls]};
      mem_raddr     = head_off_ff[cinfo.cls][scfa_pkg::OFFSET_W-1:scfa_pkg::GRANULE_SHIFT];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               size_in   = req_size_bytes;
               offset_in = req_slot_offset;
               live_in   = req_live_count;
               retry_in  = req_retry;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               // default response: done, fields zero
               rsp_valid_in = 1'b1;
               status_in    = scfa_pkg::ST_DONE;
               roff_in      = '0;
               rcls_in      = '0;
               rsb_in       = '0;
               state_in     = ST_IDLE;
               unique case (func_ff)
                  scfa_pkg::FUNC_ALLOC: begin
                     if (cinfo.oversize) begin
                        bytes_in  = bytes_sat;
                        status_in = scfa_pkg::ST_LARGE;
                     end else begin
                        rcls_in = cinfo.cls;
                        rsb_in  = cinfo.slot_bytes;
                        if (!retry_ff && (stress_ff || over_budget)) begin
                           status_in = scfa_pkg::ST_COLLECT;
                        end else if (head_valid_ff[cinfo.cls]) begin
                           // pop: fetch next link, finish in the pop state
                           rsp_valid_in = 1'b0;
                           mem_re       = 1'b1;
                           state_in     = ST_POP;
                        end else if (bump_end > RegionLimit) begin
                           status_in = scfa_pkg::ST_FULL;
                        end else begin
                           bump_in   = bump_end[scfa_pkg::OFFSET_W:0];
                           bytes_in  = bytes_sat;
                           status_in = scfa_pkg::ST_BUMPED;
                           roff_in   = bump_ff[scfa_pkg::OFFSET_W-1:0];
                        end
                     end
                  end
                  scfa_pkg::FUNC_FREE: begin
                     if (cinfo.oversize) begin
                        status_in = scfa_pkg::ST_BAD_SIZE;
                     end else begin
                        rcls_in = cinfo.cls;
                        rsb_in  = cinfo.slot_bytes;
                        if ((offset_ff[scfa_pkg::GRANULE_SHIFT-1:0] != '0) ||
                            (free_end > RegionLimit)) begin
                           status_in = scfa_pkg::ST_BAD_SIZE;
                        end else begin
                           // push: old head becomes the slot's link
                           mem_we                   = 1'b1;
                           head_valid_in[cinfo.cls] = 1'b1;
                           head_off_in[cinfo.cls]   = offset_ff;
                        end
                     end
                  end
                  scfa_pkg::FUNC_CLEAR: begin
                     head_valid_in = '0;
                  end
                  scfa_pkg::FUNC_ENDC: begin
                     bytes_in = '0;
                     if (!stress_ff) begin
                        thr_in = {4'd0, thr_next};
                     end
                  end
                  default: begin
                     status_in = scfa_pkg::ST_DONE;
                  end
               endcase
            end
         end
         ST_POP: begin
            if (out_free) begin
               head_valid_in[cinfo.cls] = link_rdata_ff[scfa_pkg::OFFSET_W];
               head_off_in[cinfo.cls]   = link_rdata_ff[scfa_pkg::OFFSET_W-1:0];
               bytes_in                 = bytes_sat;
               rsp_valid_in             = 1'b1;
               status_in                = scfa_pkg::ST_FROM_LIST;
               roff_in                  = head_off_ff[cinfo.cls];
               rcls_in                  = cinfo.cls;
               rsb_in                   = cinfo.slot_bytes;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes
      if (cfg_wr) begin
         unique case (paddr[4:3])
            scfa_pkg::CFG_STRESS: stress_in = pwdata[0];
            scfa_pkg::CFG_TMIN:   tmin_in   = pwdata[scfa_pkg::LIVE_W-1:0];
            scfa_pkg::CFG_FACTOR: factor_in = pwdata[scfa_pkg::FACTOR_W-1:0];
            default:              stress_in = stress_ff;
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         head_valid_ff <= '0;
         bump_ff       <= '0;
         bytes_ff      <= '0;
         thr_ff        <= scfa_pkg::THRESHOLD_RESET;
         stress_ff     <= 1'b0;
         tmin_ff       <= scfa_pkg::TMIN_RESET;
         factor_ff     <= scfa_pkg::FACTOR_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_valid_ff <= head_valid_in;
         bump_ff       <= bump_in;
         bytes_ff      <= bytes_in;
         thr_ff        <= thr_in;
         stress_ff     <= stress_in;
         tmin_ff       <= tmin_in;
         factor_ff     <= factor_in;
         head_off_ff   <= head_off_in;
         func_ff       <= func_in;
         size_ff       <= size_in;
         offset_ff     <= offset_in;
         live_ff       <= live_in;
         retry_ff      <= retry_in;
         status_ff     <= status_in;
         roff_ff       <= roff_in;
         rcls_ff       <= rcls_in;
         rsb_ff        <= rsb_in;
      end
   end

   // link RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         link_rdata_ff <= link_mem[mem_raddr];
      end
   end

   // register readback
   always_comb begin
      unique case (paddr[4:3])
         scfa_pkg::CFG_STRESS: prdata = {63'd0, stress_ff};
         scfa_pkg::CFG_TMIN:   prdata = {24'd0, tmin_ff};
         scfa_pkg::CFG_FACTOR: prdata = {60'd0, factor_ff};
         default:              prdata = '0;
      endcase
   end

   assign pready            = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_offset = roff_ff;
   assign rsp_size_class    = rcls_ff;
   assign rsp_slot_bytes    = rsb_ff;

endmodule
